FILE: hdl/bmm_pkg.sv
`timescale 1ns / 1ps
// Package with the shared types and constants of the block matrix multiplier.
package bmm_pkg;
    localparam int MAX_DIM    = 8;
    localparam int MAX_INNER  = 64;
    localparam int DIM_W      = $clog2(MAX_DIM) > 0 ? $clog2(MAX_DIM) : 1;
    localparam int INNER_W    = $clog2(MAX_INNER) > 0 ? $clog2(MAX_INNER) : 1;
    localparam int SUM_W      = 40;
    localparam int VAL_W      = 16;
    localparam int PROD_W     = 32;
    localparam int IN_TDATA_W = 32;
    localparam int OUT_TDATA_W = 48;

    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;

    localparam logic REG_INNER_LEN = 1'b0;
    localparam logic REG_OUT_DIM   = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_EMIT
    } t_state;

    // Control handed from the sequencer to every cell.
    typedef struct packed {
        logic             clear;
        logic             step;
        logic [VAL_W-1:0] a_val;
    } t_cell_ctl;
endpackage

FILE: hdl/bmm_cell.sv
`timescale 1ns / 1ps
// One multiply-accumulate cell: owns one column of B and one column of C's current row.
module bmm_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bmm_pkg::t_cell_ctl            i_ctl,
    input  logic                          i_b_we,
    input  logic [bmm_pkg::INNER_W-1:0]   i_b_waddr,
    input  logic [bmm_pkg::VAL_W-1:0]     i_b_wdata,
    input  logic [bmm_pkg::INNER_W-1:0]   i_b_raddr,
    input  logic                          i_shift,
    input  logic [bmm_pkg::SUM_W-1:0]     i_sum_prev,
    output logic [bmm_pkg::SUM_W-1:0]     o_sum
);
    import bmm_pkg::*;

    logic [VAL_W-1:0]  r_bmem [MAX_INNER];
    logic [VAL_W-1:0]  r_b;
    logic [VAL_W-1:0]  r_a;
    logic              r_pv;
    logic [PROD_W-1:0] r_prod;
    logic              r_pv2;
    logic [SUM_W-1:0]  r_acc;
    logic [SUM_W-1:0]  n_acc;

    always_ff @(posedge i_clk) begin
        if (i_b_we) begin
            r_bmem[i_b_waddr] <= i_b_wdata;
        end
        r_b    <= r_bmem[i_b_raddr];
        r_a    <= i_ctl.a_val;
        r_prod <= PROD_W'($signed(r_a) * $signed(r_b));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv  <= 1'b0;
            r_pv2 <= 1'b0;
        end else begin
            r_pv  <= i_ctl.step;
            r_pv2 <= r_pv;
        end
    end

    always_comb begin
        n_acc = r_acc;
        if (i_ctl.clear) begin
            n_acc = '0;
        end else if (i_shift) begin
            n_acc = i_sum_prev;
        end else if (r_pv2) begin
            n_acc = r_acc + SUM_W'($signed(r_prod));
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc <= n_acc;
    end

    assign o_sum = r_acc;
endmodule

FILE: hdl/block_matrix_multiply.sv
`timescale 1ns / 1ps
// Block matrix multiplier: top level with sequencer, A memory and the cell chain.
//
// Load transactions (kind 0 or 1) each write one element of A or B; loads outside
// the configured sizes are dropped. A start transaction walks C one row at a time:
// the row of A is read from one memory port, one element per cycle, and broadcast
// to a chain of MAX_DIM cells, each holding one column of B and accumulating one
// element of the row. A row's compute phase is skipped when inner_len is zero,
// and inner_len above MAX_INNER counts as MAX_INNER; then the row's out_dim
// results shift out of the chain one per accepted output transaction. No input
// is accepted while a start is in progress.
module block_matrix_multiply (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: kind[1:0], row[7:2], col[13:8], value[29:14], zero pad [31:30]
    input  logic [bmm_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: out_row[2:0], out_col[5:3], sum[45:6], zero pad [47:46]
    output logic [bmm_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                             m_axis_tlast,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic                             i_cfg_index,
    input  logic [6:0]                       i_cfg_data
);
    import bmm_pkg::*;

    localparam int DW1 = DIM_W + 1;
    localparam int IW1 = INNER_W + 1;

    logic [6:0] r_inner_len;
    logic [3:0] r_out_dim;
    logic [IW1-1:0] w_m;
    logic [DW1-1:0] w_n;

    t_state r_state, n_state;
    logic [INNER_W-1:0] r_k, n_k;
    logic [DIM_W-1:0]   r_i, n_i;
    logic [DIM_W-1:0]   r_j, n_j;
    logic [1:0]         r_dc, n_dc;

    logic [VAL_W-1:0] r_amem [MAX_DIM*MAX_INNER];
    logic [VAL_W-1:0] r_a_rd;

    logic [1:0]  w_kind;
    logic [5:0]  w_row, w_col;
    logic [VAL_W-1:0] w_val;
    logic        w_acc_in;
    logic        w_a_we, w_b_we;
    logic        w_clear, w_step, w_shift;
    t_cell_ctl   w_ctl;
    logic [SUM_W-1:0] w_sums [MAX_DIM+1];

    assign w_m = (r_inner_len > 7'(MAX_INNER)) ? IW1'(MAX_INNER) : IW1'(r_inner_len);
    assign w_n = (r_out_dim > 4'(MAX_DIM)) ? DW1'(MAX_DIM) : DW1'(r_out_dim);

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner_len <= 7'(64);
            r_out_dim   <= 4'(8);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_INNER_LEN: r_inner_len <= i_cfg_data;
                REG_OUT_DIM:   r_out_dim   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign w_kind = s_axis_tdata[1:0];
    assign w_row  = s_axis_tdata[7:2];
    assign w_col  = s_axis_tdata[13:8];
    assign w_val  = s_axis_tdata[29:14];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_acc_in = s_axis_tvalid && s_axis_tready;

    assign w_a_we = w_acc_in && (w_kind == KIND_LOAD_A) && (7'(w_row) < 7'(w_n))
                    && (7'(w_col) < 7'(w_m));
    assign w_b_we = w_acc_in && (w_kind == KIND_LOAD_B) && (7'(w_row) < 7'(w_m))
                    && (7'(w_col) < 7'(w_n));

    always_ff @(posedge i_clk) begin
        if (w_a_we) begin
            r_amem[{w_row[DIM_W-1:0], w_col[INNER_W-1:0]}] <= w_val;
        end
        r_a_rd <= r_amem[{r_i, r_k}];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k <= '0;
            r_i <= '0;
            r_j <= '0;
            r_dc <= '0;
        end else begin
            r_state <= n_state;
            r_k <= n_k;
            r_i <= n_i;
            r_j <= n_j;
            r_dc <= n_dc;
        end
    end

    // RUN issues one A read per cycle; DRAIN waits for the read, multiply and add.
    always_comb begin
        n_state = r_state;
        n_k = r_k;
        n_i = r_i;
        n_j = r_j;
        n_dc = r_dc;
        w_clear = 1'b0;
        w_step = 1'b0;
        w_shift = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_acc_in && w_kind == KIND_START && w_n != '0) begin
                    n_i = '0;
                    n_k = '0;
                    w_clear = 1'b1;
                    n_state = (w_m == '0) ? ST_EMIT : ST_RUN;
                    n_j = '0;
                end
            end
            ST_RUN: begin
                w_step = 1'b1;
                if (IW1'(r_k) == w_m - IW1'(1)) begin
                    n_k = '0;
                    n_dc = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + INNER_W'(1);
                end
            end
            ST_DRAIN: begin
                n_dc = r_dc + 2'd1;
                if (r_dc == 2'd2) begin
                    n_j = '0;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_axis_tready) begin
                    w_shift = 1'b1;
                    n_j = r_j + DIM_W'(1);
                    if (DW1'(r_j) == w_n - DW1'(1)) begin
                        n_j = '0;
                        w_clear = 1'b1;
                        if (DW1'(r_i) == w_n - DW1'(1)) begin
                            n_i = '0;
                            n_state = ST_IDLE;
                        end else begin
                            n_i = r_i + DIM_W'(1);
                            n_state = (w_m == '0) ? ST_EMIT : ST_RUN;
                        end
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // The A read is registered, landing in the cycle after the step, and the cell
    // registers it again, so the step and B read address are registered here too.
    assign w_ctl.clear = w_clear;
    assign w_ctl.step  = w_step;
    assign w_ctl.a_val = r_a_rd;

    logic r_step_d;
    logic [INNER_W-1:0] r_k_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_d <= 1'b0;
            r_k_d    <= '0;
        end else begin
            r_step_d <= w_step;
            r_k_d    <= r_k;
        end
    end
    t_cell_ctl w_ctl_d;
    assign w_ctl_d.clear = w_clear;
    assign w_ctl_d.step  = r_step_d;
    assign w_ctl_d.a_val = r_a_rd;

    assign w_sums[MAX_DIM] = '0;
    for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
        bmm_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl_d),
            .i_b_we     (w_b_we && (w_col[DIM_W-1:0] == DIM_W'(c))),
            .i_b_waddr  (w_row[INNER_W-1:0]),
            .i_b_wdata  (w_val),
            .i_b_raddr  (r_k_d),
            .i_shift    (w_shift),
            .i_sum_prev (w_sums[c+1]),
            .o_sum      (w_sums[c])
        );
    end

    assign m_axis_tvalid = (r_state == ST_EMIT);
    assign m_axis_tdata  = {2'b00, w_sums[0], r_j, r_i};
    assign m_axis_tlast  = (DW1'(r_j) == w_n - DW1'(1)) && (DW1'(r_i) == w_n - DW1'(1));

    logic w_unused;
    assign w_unused = w_ctl.clear ^ w_ctl.step ^ (^w_ctl.a_val) ^ (^s_axis_tdata[31:30]);
endmodule
